// ===== rtl/id3_text_to_utf8_core_defines.svh =====
// Assertion macros used by the back end of the text-to-UTF-8 transcoder RTL.
`ifndef ID3_TEXT_TO_UTF8_CORE_DEFINES_SVH
`define ID3_TEXT_TO_UTF8_CORE_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define ID3TU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// Concurrent check that also holds while reset is asserted.
`define ID3TU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

// ===== rtl/id3tu_pkg.sv =====
// Shared types and constants of the text-to-UTF-8 transcoder.
package id3tu_pkg;

  localparam int unsigned MAX_CAPACITY = 1024;
  localparam int unsigned CAP_W        = 11;
  localparam int unsigned WC_W         = 10;
  localparam int unsigned CP_W         = 21;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = 2;
  localparam int unsigned QCNT_W       = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd64;
  localparam logic [CAP_W-1:0] CAP_MAX   = 11'd1024;
  localparam logic [CAP_W-1:0] CAP_MIN   = 11'd1;

  // Encoding byte codes
  localparam logic [1:0] ENC_LATIN1    = 2'd0;
  localparam logic [1:0] ENC_UTF16_BOM = 2'd1;
  localparam logic [1:0] ENC_UTF16_BE  = 2'd2;
  localparam logic [1:0] ENC_UTF8      = 2'd3;

  localparam logic [7:0]      CHAR_QMARK   = 8'h3F;
  localparam logic [7:0]      BOM_FF       = 8'hFF;
  localparam logic [7:0]      BOM_FE       = 8'hFE;
  localparam logic [5:0]      SURR_HI_TAG  = 6'b110110;
  localparam logic [5:0]      SURR_LO_TAG  = 6'b110111;
  localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h10000;

  // One queue entry: an optional leading '?', one code point of 0 to 4
  // bytes, and an optional terminator with the frame length.
  typedef struct packed {
    logic            pre_q_mark;
    logic [CP_W-1:0] cp;
    logic [2:0]      cp_len;
    logic            term;
    logic [WC_W-1:0] term_len;
  } job_t;

endpackage

// ===== rtl/id3tu_in_if.sv =====
// Input channel: one payload byte of a text frame per beat.
interface id3tu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_first;
  logic       is_last;

  modport source (output valid, output in_byte, output is_first, output is_last,
                  input ready);
  modport sink   (input valid, input in_byte, input is_first, input is_last,
                  output ready);
endinterface

// ===== rtl/id3tu_out_if.sv =====
// Output channel: one UTF-8 byte or the terminator per beat.
interface id3tu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;
  logic [9:0] out_length;

  modport source (output valid, output out_byte, output is_terminator,
                  output out_length, input ready);
  modport sink   (input valid, input out_byte, input is_terminator,
                  input out_length, output ready);
endinterface

// ===== rtl/id3tu_front.sv =====
// Front end: accepts payload bytes, tracks the frame and decodes characters.
module id3tu_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [10:0]            cap_i,
  id3tu_in_if.sink               in_i,
  input  logic                   full_i,
  output logic                   push_o,
  output id3tu_pkg::job_t        job_o
);

  logic [1:0]  enc_q, enc_d;
  logic        le_q, le_d;
  logic        phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic        fw_q, fw_d;
  logic [9:0]  ph_q, ph_d;
  logic        pv_q, pv_d;
  logic [9:0]  wc_q, wc_d;
  logic        stop_q, stop_d;
  logic        accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    logic [15:0] w;
    logic [11:0] wc1;
    logic [11:0] cap_x;
    logic [2:0]  clen;
    logic        lo;
    logic        hi;
    logic        word_done;
    logic [7:0]  b;

    b         = in_i.in_byte;
    w         = le_q ? {b, held_q} : {held_q, b};
    lo        = (w[15:10] == id3tu_pkg::SURR_LO_TAG);
    hi        = (w[15:10] == id3tu_pkg::SURR_HI_TAG);
    wc1       = {2'b00, wc_q};
    cap_x     = {1'b0, cap_i};
    clen      = 3'd0;
    word_done = 1'b0;

    enc_d   = enc_q;
    le_d    = le_q;
    phase_d = phase_q;
    held_d  = held_q;
    fw_d    = fw_q;
    ph_d    = ph_q;
    pv_d    = pv_q;
    stop_d  = stop_q;
    job_o   = '0;

    if (accept) begin
      if (in_i.is_first) begin
        enc_d   = (b == 8'd1 || b == 8'd2 || b == 8'd3) ? b[1:0]
                                                         : id3tu_pkg::ENC_LATIN1;
        le_d    = (b == 8'd1);
        phase_d = 1'b0;
        held_d  = 8'h00;
        fw_d    = 1'b1;
        ph_d    = 10'd0;
        pv_d    = 1'b0;
        stop_d  = 1'b0;
        wc1     = 12'd0;
      end else if (!stop_q) begin
        case (enc_q)
          id3tu_pkg::ENC_LATIN1: begin
            clen = b[7] ? 3'd2 : 3'd1;
            if (b == 8'h00 || (wc1 + {9'd0, clen}) >= cap_x) begin
              stop_d = 1'b1;
            end else begin
              job_o.cp     = {13'd0, b};
              job_o.cp_len = clen;
              wc1          = wc1 + {9'd0, clen};
            end
          end
          id3tu_pkg::ENC_UTF8: begin
            if (b == 8'h00 || (wc1 + 12'd1) >= cap_x) begin
              stop_d = 1'b1;
            end else begin
              job_o.cp     = {13'd0, b};
              job_o.cp_len = 3'd1;
              wc1          = wc1 + 12'd1;
            end
          end
          default: begin
            if (!phase_q) begin
              held_d  = b;
              phase_d = 1'b1;
            end else begin
              phase_d = 1'b0;
              fw_d    = 1'b0;
              if (fw_q && held_q == id3tu_pkg::BOM_FF && b == id3tu_pkg::BOM_FE) begin
                le_d = 1'b1;
              end else if (fw_q && held_q == id3tu_pkg::BOM_FE &&
                           b == id3tu_pkg::BOM_FF) begin
                le_d = 1'b0;
              end else begin
                if (pv_q) begin
                  pv_d = 1'b0;
                  if (lo) begin
                    word_done = 1'b1;
                    if ((wc1 + 12'd4) >= cap_x) begin
                      stop_d = 1'b1;
                    end else begin
                      job_o.cp     = id3tu_pkg::CP_SUPP_BASE + {1'b0, ph_q, w[9:0]};
                      job_o.cp_len = 3'd4;
                      wc1          = wc1 + 12'd4;
                    end
                  end else if ((wc1 + 12'd1) >= cap_x) begin
                    word_done = 1'b1;
                    stop_d    = 1'b1;
                  end else begin
                    job_o.pre_q_mark = 1'b1;
                    wc1              = wc1 + 12'd1;
                  end
                end
                if (!word_done) begin
                  if (w == 16'h0000) begin
                    stop_d = 1'b1;
                  end else if (hi) begin
                    ph_d = w[9:0];
                    pv_d = 1'b1;
                  end else begin
                    if (lo) begin
                      clen         = 3'd1;
                      job_o.cp     = {13'd0, id3tu_pkg::CHAR_QMARK};
                    end else begin
                      clen         = (w < 16'h0080) ? 3'd1 :
                                     (w < 16'h0800) ? 3'd2 : 3'd3;
                      job_o.cp     = {5'd0, w};
                    end
                    if ((wc1 + {9'd0, clen}) >= cap_x) begin
                      stop_d   = 1'b1;
                      job_o.cp = '0;
                    end else begin
                      job_o.cp_len = clen;
                      wc1          = wc1 + {9'd0, clen};
                    end
                  end
                end
              end
            end
          end
        endcase
      end

      if (in_i.is_last) begin
        // A high surrogate still open at frame end becomes '?'; the code
        // point slot is always free in that case.
        if (pv_d && !stop_d && (wc1 + 12'd1) < cap_x) begin
          job_o.cp     = {13'd0, id3tu_pkg::CHAR_QMARK};
          job_o.cp_len = 3'd1;
          wc1          = wc1 + 12'd1;
        end
        job_o.term     = 1'b1;
        job_o.term_len = wc1[9:0];
        enc_d   = id3tu_pkg::ENC_LATIN1;
        le_d    = 1'b0;
        phase_d = 1'b0;
        held_d  = 8'h00;
        fw_d    = 1'b1;
        ph_d    = 10'd0;
        pv_d    = 1'b0;
        stop_d  = 1'b0;
        wc1     = 12'd0;
      end
    end

    wc_d   = wc1[9:0];
    push_o = accept && (job_o.pre_q_mark || job_o.cp_len != 3'd0 || job_o.term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q   <= id3tu_pkg::ENC_LATIN1;
      le_q    <= 1'b0;
      phase_q <= 1'b0;
      held_q  <= 8'h00;
      fw_q    <= 1'b1;
      ph_q    <= 10'd0;
      pv_q    <= 1'b0;
      wc_q    <= 10'd0;
      stop_q  <= 1'b0;
    end else begin
      enc_q   <= enc_d;
      le_q    <= le_d;
      phase_q <= phase_d;
      held_q  <= held_d;
      fw_q    <= fw_d;
      ph_q    <= ph_d;
      pv_q    <= pv_d;
      wc_q    <= wc_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// ===== rtl/id3tu_queue.sv =====
// Short job queue between the decoding front end and the byte serialiser.
module id3tu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  id3tu_pkg::job_t  job_i,
  output logic             full_o,
  input  logic             pop_i,
  output id3tu_pkg::job_t  head_o,
  output logic             avail_o
);

  id3tu_pkg::job_t                mem_q [id3tu_pkg::QUEUE_DEPTH];
  logic [id3tu_pkg::QPTR_W-1:0]   wr_q, wr_d;
  logic [id3tu_pkg::QPTR_W-1:0]   rd_q, rd_d;
  logic [id3tu_pkg::QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == id3tu_pkg::QCNT_W'(id3tu_pkg::QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/id3tu_back.sv =====
// Back end: turns queued jobs into UTF-8 bytes, one output beat per cycle unless stalled.
`include "id3_text_to_utf8_core_defines.svh"

module id3tu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  id3tu_pkg::job_t  head_i,
  input  logic             avail_i,
  output logic             pop_o,
  id3tu_out_if.source      out_o
);

  logic        wv_q, wv_d;
  logic        wpre_q, wpre_d;
  logic [2:0]  wleft_q, wleft_d;
  logic [2:0]  wlen_q, wlen_d;
  logic [20:0] wcp_q, wcp_d;
  logic        wterm_q, wterm_d;
  logic [9:0]  wtlen_q, wtlen_d;

  logic        ov_q, ov_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        oterm_q, oterm_d;
  logic [9:0]  olen_q, olen_d;

  logic        adv;
  logic        step;

  assign adv  = !ov_q || out_o.ready;
  assign step = adv && wv_q;

  always_comb begin
    logic [7:0] cbyte;
    logic       remain;

    // Byte of the current code point picked by how many bytes are left.
    if (wleft_q == wlen_q) begin
      case (wlen_q)
        3'd1:    cbyte = wcp_q[7:0];
        3'd2:    cbyte = {3'b110, wcp_q[10:6]};
        3'd3:    cbyte = {4'b1110, wcp_q[15:12]};
        default: cbyte = {5'b11110, wcp_q[20:18]};
      endcase
    end else begin
      case (wleft_q)
        3'd2:    cbyte = {2'b10, wcp_q[11:6]};
        3'd3:    cbyte = {2'b10, wcp_q[17:12]};
        default: cbyte = {2'b10, wcp_q[5:0]};
      endcase
    end

    wv_d    = wv_q;
    wpre_d  = wpre_q;
    wleft_d = wleft_q;
    wlen_d  = wlen_q;
    wcp_d   = wcp_q;
    wterm_d = wterm_q;
    wtlen_d = wtlen_q;
    ov_d    = ov_q;
    obyte_d = obyte_q;
    oterm_d = oterm_q;
    olen_d  = olen_q;

    if (adv) begin
      ov_d    = step;
      obyte_d = 8'h00;
      oterm_d = 1'b0;
      olen_d  = 10'd0;
    end

    if (step) begin
      if (wpre_q) begin
        obyte_d = id3tu_pkg::CHAR_QMARK;
        wpre_d  = 1'b0;
      end else if (wleft_q != 3'd0) begin
        obyte_d = cbyte;
        wleft_d = wleft_q - 3'd1;
      end else begin
        oterm_d = 1'b1;
        olen_d  = wtlen_q;
        wterm_d = 1'b0;
      end
    end

    remain = wpre_d || (wleft_d != 3'd0) || wterm_d;
    pop_o  = avail_i && (!wv_q || (step && !remain));

    if (pop_o) begin
      wv_d    = 1'b1;
      wpre_d  = head_i.pre_q_mark;
      wleft_d = head_i.cp_len;
      wlen_d  = head_i.cp_len;
      wcp_d   = head_i.cp;
      wterm_d = head_i.term;
      wtlen_d = head_i.term_len;
    end else if (step && !remain) begin
      wv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q    <= 1'b0;
      wpre_q  <= 1'b0;
      wleft_q <= 3'd0;
      wterm_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      wv_q    <= wv_d;
      wpre_q  <= wpre_d;
      wleft_q <= wleft_d;
      wterm_q <= wterm_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wlen_q  <= wlen_d;
    wcp_q   <= wcp_d;
    wtlen_q <= wtlen_d;
    obyte_q <= obyte_d;
    oterm_q <= oterm_d;
    olen_q  <= olen_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_byte      = obyte_q;
  assign out_o.is_terminator = oterm_q;
  assign out_o.out_length    = olen_q;

  // A loaded job always has at least one beat still to give.
  `ID3TU_ASSERT(a_work_nonempty, clk_i, rst_ni,
                wv_q |-> (wpre_q || wleft_q != 3'd0 || wterm_q))
  // The terminator beat carries a zero byte.
  `ID3TU_ASSERT(a_term_zero, clk_i, rst_ni,
                (ov_q && oterm_q) |-> (obyte_q == 8'h00))
  // Data beats never report a length.
  `ID3TU_ASSERT(a_len_on_term, clk_i, rst_ni,
                (ov_q && !oterm_q) |-> (olen_q == 10'd0))

endmodule

// ===== rtl/id3_text_to_utf8_core.sv =====
// Top level of the ID3v2 text frame to UTF-8 transcoder.
//
// Usage: payload bytes of a text frame arrive on in_i, one per beat, the
// encoding byte flagged is_first and the final byte flagged is_last. The
// block returns UTF-8 bytes on out_o, closed by a terminator beat (zero
// byte, is_terminator high) that carries the number of bytes written.
// cfg_we_i/cfg_wdata_i set the destination capacity including the null;
// it must only be changed while the block is idle.
//
// Path: an accepted item enters the job queue, then the serialiser's work
// register, and its beats leave through the output register. An item is
// taken every cycle while the job queue has room; it expands to at most
// five beats, sent one a cycle while the receiver is ready.
//
// Reset clears the frame state and the queue and sets the capacity to 64.
// When the receiver stalls, the output register holds its beat, the
// four-entry job queue fills and only then is in_i.ready dropped.
module id3_text_to_utf8_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  id3tu_in_if.sink    in_i,
  id3tu_out_if.source out_o
);

  logic [10:0]     cap_q;
  logic [10:0]     cap_eff;
  logic            push;
  logic            pop;
  logic            full;
  logic            avail;
  id3tu_pkg::job_t job_in;
  id3tu_pkg::job_t job_head;

  // Capacity register, held raw and clamped to the legal range on use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= id3tu_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign cap_eff = (cap_q == 11'd0)              ? id3tu_pkg::CAP_MIN :
                   (cap_q > id3tu_pkg::CAP_MAX)  ? id3tu_pkg::CAP_MAX : cap_q;

  // The front end decodes each accepted byte into at most one job.
  id3tu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cap_i  (cap_eff),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  // The queue decouples decoding from the byte-at-a-time output.
  id3tu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (job_head),
    .avail_o (avail)
  );

  // The back end serialises each job into UTF-8 beats.
  id3tu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (job_head),
    .avail_i (avail),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the ID3v2 text frame to UTF-8 transcoder.
`timescale 1ns / 100ps

module tb;

  // The run stops here at the latest; the slowest correct run stays below it,
  // with every beat expanding to five output beats behind receiver stalls, plus
  // the quiet periods around each capacity change.
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned ITEMS_TOTAL  = 370;
  // Cycles allowed after the last expected beat, so that the block has settled
  // idle before a capacity change.
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned NUM_PHASES   = 8;

  // UTF-8 lead and continuation tags.
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

  typedef logic [7:0] byte_q[$];

  // The scoreboard holds its own copy of the frame state and the capacity. Each
  // accepted payload beat is converted here, and the UTF-8 beats that it
  // produces are queued until the block returns them.
  class utf8_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       term;
      logic [9:0] length;
    } utf8_beat_t;

    utf8_beat_t  awaited[$];
    logic [10:0] capacity;
    logic [1:0]  enc_kind;
    bit          little_end;
    bit          odd_half;
    logic [7:0]  held;
    bit          first_word;
    logic [15:0] high_half;
    bit          high_pending;
    int unsigned written;
    bit          halted;
    int unsigned n_fail;
    int unsigned n_beats;
    int unsigned n_terms;

    function new();
      capacity = id3tu_pkg::CAP_RESET;
      n_fail   = 0;
      n_beats  = 0;
      n_terms  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      enc_kind     = id3tu_pkg::ENC_LATIN1;
      little_end   = 1'b0;
      odd_half     = 1'b0;
      held         = 8'h00;
      first_word   = 1'b1;
      high_half    = 16'h0000;
      high_pending = 1'b0;
      written      = 0;
      halted       = 1'b0;
    endfunction

    function void set_capacity(logic [10:0] value);
      capacity = value;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // Capacity as the block applies it: zero means one, and anything beyond the
    // largest destination is clipped to it.
    function int unsigned dest_size();
      if (capacity == 0) return 1;
      if (capacity > id3tu_pkg::MAX_CAPACITY) return id3tu_pkg::MAX_CAPACITY;
      return capacity;
    endfunction

    function void push_beat(logic [7:0] data, logic term, int unsigned length);
      utf8_beat_t beat;
      beat.data   = data;
      beat.term   = term;
      beat.length = length[9:0];
      awaited.push_back(beat);
    endfunction

    // Encodes one code point; fails when it and the closing null would not fit.
    function bit put_code_point(logic [20:0] cp);
      int unsigned nb;
      if (cp == 0) return 1'b1;
      if (cp < 21'h80) nb = 1;
      else if (cp < 21'h800) nb = 2;
      else if (cp < 21'h10000) nb = 3;
      else nb = 4;
      if (written + nb >= dest_size()) return 1'b0;
      case (nb)
        1: push_beat(cp[7:0], 1'b0, 0);
        2: begin
          push_beat(UTF8_LEAD2 | {3'b0, cp[10:6]}, 1'b0, 0);
          push_beat(UTF8_CONT | {2'b0, cp[5:0]}, 1'b0, 0);
        end
        3: begin
          push_beat(UTF8_LEAD3 | {4'b0, cp[15:12]}, 1'b0, 0);
          push_beat(UTF8_CONT | {2'b0, cp[11:6]}, 1'b0, 0);
          push_beat(UTF8_CONT | {2'b0, cp[5:0]}, 1'b0, 0);
        end
        default: begin
          push_beat(UTF8_LEAD4 | {5'b0, cp[20:18]}, 1'b0, 0);
          push_beat(UTF8_CONT | {2'b0, cp[17:12]}, 1'b0, 0);
          push_beat(UTF8_CONT | {2'b0, cp[11:6]}, 1'b0, 0);
          push_beat(UTF8_CONT | {2'b0, cp[5:0]}, 1'b0, 0);
        end
      endcase
      written += nb;
      return 1'b1;
    endfunction

    // One complete UTF-16 word, after byte order has been applied.
    function void decode_utf16_word(logic [15:0] w);
      logic [20:0] cp;
      if (halted) return;
      if (high_pending) begin
        high_pending = 1'b0;
        if (w[15:10] == id3tu_pkg::SURR_LO_TAG) begin
          cp = id3tu_pkg::CP_SUPP_BASE + {1'b0, high_half[9:0], w[9:0]};
          if (!put_code_point(cp)) halted = 1'b1;
          return;
        end
        // The high half had no partner: it becomes a question mark and the
        // current word is then taken on its own.
        if (!put_code_point({13'b0, id3tu_pkg::CHAR_QMARK})) begin
          halted = 1'b1;
          return;
        end
      end
      if (w == 16'h0000) begin
        halted = 1'b1;
        return;
      end
      if (w[15:10] == id3tu_pkg::SURR_HI_TAG) begin
        high_half    = w;
        high_pending = 1'b1;
        return;
      end
      cp = (w[15:10] == id3tu_pkg::SURR_LO_TAG) ? {13'b0, id3tu_pkg::CHAR_QMARK}
                                                : {5'b0, w};
      if (!put_code_point(cp)) halted = 1'b1;
    endfunction

    function void decode_payload_byte(logic [7:0] b);
      if (halted) return;
      case (enc_kind)
        id3tu_pkg::ENC_LATIN1: begin
          if (b == 8'h00 || !put_code_point({13'b0, b})) halted = 1'b1;
        end
        id3tu_pkg::ENC_UTF8: begin
          if (b == 8'h00 || written + 1 >= dest_size()) begin
            halted = 1'b1;
          end else begin
            push_beat(b, 1'b0, 0);
            written++;
          end
        end
        default: begin
          if (!odd_half) begin
            held     = b;
            odd_half = 1'b1;
          end else begin
            odd_half = 1'b0;
            // Only the very first word of the frame may be a byte-order mark.
            if (first_word) begin
              first_word = 1'b0;
              if (held == id3tu_pkg::BOM_FF && b == id3tu_pkg::BOM_FE) begin
                little_end = 1'b1;
                return;
              end
              if (held == id3tu_pkg::BOM_FE && b == id3tu_pkg::BOM_FF) begin
                little_end = 1'b0;
                return;
              end
            end
            decode_utf16_word(little_end ? {b, held} : {held, b});
          end
        end
      endcase
    endfunction

    // Notes one accepted input beat and queues the UTF-8 beats it causes.
    function void take_payload_byte(logic [7:0] b, logic first, logic last);
      if (first) begin
        clear_frame();
        if (b != 8'h00 && b <= id3tu_pkg::ENC_UTF8) enc_kind = b[1:0];
        little_end = (b == id3tu_pkg::ENC_UTF16_BOM);
      end else begin
        decode_payload_byte(b);
      end
      if (last) begin
        // A high surrogate still waiting at the end of the frame is a stray one.
        if (high_pending && !halted) begin
          high_pending = 1'b0;
          void'(put_code_point({13'b0, id3tu_pkg::CHAR_QMARK}));
        end
        push_beat(8'h00, 1'b1, written);
        clear_frame();
      end
    endfunction

    // Compares one accepted output beat with the oldest queued expectation.
    function void check_utf8_beat(logic [7:0] data, logic term, logic [9:0] length);
      utf8_beat_t want;
      if (awaited.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected beat: out_byte=%02h is_terminator=%0b out_length=%0d",
                 $time, data, term, length);
        return;
      end
      want = awaited.pop_front();
      n_beats++;
      if (want.term) n_terms++;
      if (data !== want.data) begin
        n_fail++;
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, data);
      end
      if (term !== want.term) begin
        n_fail++;
        $display("%0t: is_terminator expected %0b, got %0b", $time, want.term, term);
      end
      if (length !== want.length) begin
        n_fail++;
        $display("%0t: out_length expected %0d, got %0d", $time, want.length, length);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;

  id3tu_in_if  in_ch ();
  id3tu_out_if out_ch ();

  utf8_scoreboard sb;
  int unsigned    cycle_count = 0;
  int unsigned    items_sent  = 0;
  int unsigned    cap_writes  = 0;
  bit             mid_frame   = 1'b0;
  // While set, the corresponding side of the bench never idles.
  bit             send_calm   = 1'b0;
  bit             recv_calm   = 1'b0;

  id3_text_to_utf8_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Both channels are sampled on the rising edge, before any register of the
  // block has taken its new value. The input beat is noted first so that its
  // expectations are already queued should its output appear in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.take_payload_byte(in_ch.in_byte, in_ch.is_first, in_ch.is_last);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_utf8_beat(out_ch.out_byte, out_ch.is_terminator, out_ch.out_length);
      end
    end
  end

  // The receiver stalls at random, with a chance of eight in a hundred, except
  // during the calm stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= recv_calm || ($urandom_range(0, 99) >= 8);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d beats still awaited",
             cycle_count, sb.outstanding());
    $display("id3_text_to_utf8_core verification failed");
    $finish;
  end

  // Every driving task is entered just after a falling edge and returns just
  // after one, so that valid receives at most one assignment per time step.
  task automatic send_byte(logic [7:0] b, bit first, bit last);
    while (!send_calm && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.is_first <= first;
    in_ch.is_last  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    items_sent++;
    mid_frame = !last;
  endtask

  task automatic send_frame(logic [7:0] enc, byte_q body, bit with_first, bit with_last);
    if (with_first) send_byte(enc, 1'b1, with_last && body.size() == 0);
    foreach (body[i]) send_byte(body[i], 1'b0, with_last && i == body.size() - 1);
  endtask

  // Holds the input back until the block has returned every expected beat.
  // The loop waits for a falling edge before it checks, so valid is never
  // lowered and raised again within one time step.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
  endtask

  // The capacity is only changed between frames with the block idle: any open
  // frame is closed first, then every beat is collected and the job queue is
  // given time to empty.
  task automatic load_capacity(logic [10:0] value);
    if (mid_frame) send_byte(8'($urandom), 1'b0, 1'b1);
    wait_for_drain();
    repeat (QUIET_CYCLES) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_capacity(value);
    cap_writes++;
  endtask

  // One random frame. Most are well formed with random content; a share are
  // loose beats with random flags, and a few frames lose their encoding beat
  // or their closing flag.
  task automatic random_frame();
    byte_q       body;
    logic [15:0] words[$];
    logic [7:0]  enc;
    int unsigned pick;
    int unsigned span;
    int unsigned n;
    bit          le;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      return;
    end
    // Mostly short frames; the occasional long one runs into the capacity.
    span = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 70) : $urandom_range(0, 10);
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      enc = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(4, 255))
                                        : {6'b0, id3tu_pkg::ENC_LATIN1};
    end else if (pick < 6) begin
      enc = {6'b0, id3tu_pkg::ENC_UTF16_BOM};
    end else if (pick < 8) begin
      enc = {6'b0, id3tu_pkg::ENC_UTF16_BE};
    end else begin
      enc = {6'b0, id3tu_pkg::ENC_UTF8};
    end
    if (enc == id3tu_pkg::ENC_UTF16_BOM || enc == id3tu_pkg::ENC_UTF16_BE) begin
      // Words are laid out in the order the block will assume, so that
      // surrogate pairs really do meet as pairs.
      le = (enc == id3tu_pkg::ENC_UTF16_BOM);
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        body.push_back(id3tu_pkg::BOM_FF);
        body.push_back(id3tu_pkg::BOM_FE);
        le = 1'b1;
      end else if (pick == 1) begin
        body.push_back(id3tu_pkg::BOM_FE);
        body.push_back(id3tu_pkg::BOM_FF);
        le = 1'b0;
      end
      while (body.size() < span) begin
        words.delete();
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          words.push_back(16'($urandom_range('h01, 'h7F)));
        end else if (pick < 45) begin
          words.push_back(16'($urandom_range('h80, 'h7FF)));
        end else if (pick < 65) begin
          words.push_back(($urandom_range(0, 1) != 0) ? 16'($urandom_range('h800, 'hD7FF))
                                                      : 16'($urandom_range('hE000, 'hFFFF)));
        end else if (pick < 80) begin
          words.push_back(16'($urandom_range('hD800, 'hDBFF)));
          words.push_back(16'($urandom_range('hDC00, 'hDFFF)));
        end else if (pick < 87) begin
          words.push_back(16'($urandom_range('hD800, 'hDBFF)));
        end else if (pick < 93) begin
          words.push_back(16'($urandom_range('hDC00, 'hDFFF)));
        end else if (pick < 96) begin
          words.push_back(16'h0000);
        end else begin
          words.push_back(16'($urandom));
        end
        foreach (words[i]) begin
          if (le) begin
            body.push_back(words[i][7:0]);
            body.push_back(words[i][15:8]);
          end else begin
            body.push_back(words[i][15:8]);
            body.push_back(words[i][7:0]);
          end
        end
      end
      // Now and then a lone trailing byte that the block has to drop.
      if ($urandom_range(0, 99) < 15) body.push_back(8'($urandom));
    end else begin
      repeat (span) begin
        body.push_back(($urandom_range(0, 29) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
    end
    send_frame(enc, body, $urandom_range(0, 24) != 0, $urandom_range(0, 24) != 0);
  endtask

  initial begin
    byte_q        body;
    logic [10:0]  caps[NUM_PHASES];
    int unsigned  directed_items;
    int unsigned  target;
    int unsigned  frames_in_phase;
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    in_ch.is_first = 1'b0;
    in_ch.is_last  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames at the reset capacity.
    // An unknown encoding code falls back to Latin-1; a null ends the text.
    body = '{8'h41, 8'hFF, 8'h00, 8'h42};
    send_frame(8'hFF, body, 1'b1, 1'b1);
    // Little-endian mark, a surrogate pair for a four-byte character, and an
    // odd byte at the end that is dropped.
    body = '{id3tu_pkg::BOM_FF, id3tu_pkg::BOM_FE, 8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h41};
    send_frame({6'b0, id3tu_pkg::ENC_UTF16_BOM}, body, 1'b1, 1'b1);
    // Big-endian: a high half followed by an ordinary character, a lone low
    // half, and a high half left open when the frame ends.
    body = '{8'hD8, 8'h00, 8'h00, 8'hE9, 8'hDC, 8'h00, 8'hDB, 8'hFF};
    send_frame({6'b0, id3tu_pkg::ENC_UTF16_BE}, body, 1'b1, 1'b1);
    // UTF-8 passes through untouched.
    body = '{8'hE2, 8'h82, 8'hAC};
    send_frame({6'b0, id3tu_pkg::ENC_UTF8}, body, 1'b1, 1'b1);
    // Empty frame: the encoding beat carries the closing flag as well.
    body.delete();
    send_frame({6'b0, id3tu_pkg::ENC_LATIN1}, body, 1'b1, 1'b1);
    // A payload beat with no encoding beat ahead of it.
    send_byte(8'h7A, 1'b0, 1'b1);
    directed_items = items_sent;

    // Random frames in phases of differing capacity, the extremes among them.
    caps = '{11'd1, 11'd2, 11'd0, id3tu_pkg::CAP_MAX, 11'd2047, 11'd7,
             11'($urandom_range(3, 40)), id3tu_pkg::CAP_RESET};
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_capacity(caps[p]);
      // One phase runs with neither side ever idling.
      send_calm = (p == 3);
      recv_calm = (p == 3);
      target = directed_items + (p + 1) * (ITEMS_TOTAL - directed_items) / NUM_PHASES;
      frames_in_phase = 0;
      while (items_sent < target) begin
        random_frame();
        frames_in_phase++;
        if (p == 5 && frames_in_phase == 3) wait_for_drain();
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d input beats over %0d capacity settings, all four encodings",
             items_sent, cap_writes);
    $display("and %0d UTF-8 beats checked, %0d of them frame terminators.",
             sb.n_beats, sb.n_terms);
    if (sb.n_fail == 0 && sb.outstanding() == 0) begin
      $display("id3_text_to_utf8_core verification clean");
    end else begin
      $display("id3_text_to_utf8_core verification failed");
    end
    $finish;
  end

endmodule
